// ----- src/sars_pkg.sv -----
// types, constants and codes shared by the scheduler modules
`timescale 1ns / 1ps
`default_nettype none

package sars_pkg;

   // tick count and wake time width
   localparam int TICK_WIDTH = 32;

   // widths of the transaction fields
   localparam int SLICE_WIDTH = 8;
   localparam int DELAY_WIDTH = 8;
   localparam int TASK_WIDTH  = 2;
   localparam int TASK_COUNT  = 4;
   localparam int CSR_IDX_WIDTH = 3;

   // misses in a row before falling back to idle
   localparam int STREAK_WIDTH = 2;
   localparam logic [STREAK_WIDTH-1:0] TIMEOUT_MISSES = 2'd3;

   // event codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_SLEEP = 1'b1;

   // task numbers
   localparam logic [TASK_WIDTH-1:0] TASK_IDLE  = 2'd0;
   localparam logic [TASK_WIDTH-1:0] TASK_FIRST = 2'd1;
   localparam logic [TASK_WIDTH-1:0] TASK_TWO   = 2'd2;
   localparam logic [TASK_WIDTH-1:0] TASK_LAST  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDLE_SLICES  = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TASK1_SLICES = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TASK2_SLICES = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TASK3_SLICES = 3'd3;

   // register reset values
   localparam logic [SLICE_WIDTH-1:0] IDLE_SLICES_RST  = 8'd1;
   localparam logic [SLICE_WIDTH-1:0] TASK1_SLICES_RST = 8'd5;
   localparam logic [SLICE_WIDTH-1:0] TASK2_SLICES_RST = 8'd10;
   localparam logic [SLICE_WIDTH-1:0] TASK3_SLICES_RST = 8'd20;

   // one incoming event
   typedef struct packed {
      logic                   opcode;
      logic [DELAY_WIDTH-1:0] sleep_ticks;
   } event_type;

   // one scheduling result
   typedef struct packed {
      logic [TASK_WIDTH-1:0] running_task;
      logic                  switched;
      logic                  found_asleep;
   } result_type;

endpackage

`default_nettype wire

// ----- src/sars_in_reg.sv -----
// input register for event transactions
`timescale 1ns / 1ps
`default_nettype none

module sars_in_reg
   import sars_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_opcode,
   input  wire logic [DELAY_WIDTH-1:0] req_sleep_ticks,
   input  wire logic                   advance,
   output logic                        ev_valid,
   output event_type                   ev
);

   logic      valid_ff;
   logic      valid_in;
   event_type ev_ff;

   // take a new event when none is held or the held one moves on
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ev_ff.opcode      <= req_opcode;
         ev_ff.sleep_ticks <= req_sleep_ticks;
      end
   end

   assign ev_valid = valid_ff;
   assign ev       = ev_ff;

endmodule

`default_nettype wire

// ----- src/sars_core.sv -----
// scheduler state, slice registers and next-task decision
`timescale 1ns / 1ps
`default_nettype none

module sars_core
   import sars_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [SLICE_WIDTH-1:0]   csr_wdata,
   input  wire logic                     fire,
   input  wire event_type                ev,
   output result_type                    res
);

   logic [SLICE_WIDTH-1:0]  slice_cfg_ff [TASK_COUNT];
   logic [TICK_WIDTH-1:0]   tick_ff, tick_in;
   logic [TASK_WIDTH-1:0]   cur_ff, cur_in;
   logic [SLICE_WIDTH-1:0]  slices_ff, slices_in;
   logic [TICK_WIDTH-1:0]   wake_ff [TASK_COUNT];
   logic [TICK_WIDTH-1:0]   wake_in [TASK_COUNT];
   logic [STREAK_WIDTH-1:0] streak_ff, streak_in;
   logic                    handover_ff, handover_in;

   logic [TICK_WIDTH-1:0]   tick_nx;
   logic [TASK_COUNT-1:0]   wake_lt;
   logic [TASK_COUNT-1:0]   wake_gt;
   logic [TASK_WIDTH-1:0]   found;
   logic                    do_switch;
   logic                    sw;
   logic                    asleep;

   // slice registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_cfg_ff[0] <= IDLE_SLICES_RST;
         slice_cfg_ff[1] <= TASK1_SLICES_RST;
         slice_cfg_ff[2] <= TASK2_SLICES_RST;
         slice_cfg_ff[3] <= TASK3_SLICES_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IDLE_SLICES:  slice_cfg_ff[0] <= csr_wdata;
            CSR_TASK1_SLICES: slice_cfg_ff[1] <= csr_wdata;
            CSR_TASK2_SLICES: slice_cfg_ff[2] <= csr_wdata;
            CSR_TASK3_SLICES: slice_cfg_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advanced count and the wake-time compares, all in parallel
   assign tick_nx = tick_ff + {{(TICK_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      for (int i = 0; i < TASK_COUNT; i++) begin
         wake_lt[i] = wake_ff[i] < tick_nx;
         wake_gt[i] = wake_ff[i] > tick_nx;
      end
   end

   // highest-numbered worker that is strictly past its wake time
   always_comb begin
      if (wake_lt[3]) begin
         found = TASK_LAST;
      end else if (wake_lt[2]) begin
         found = TASK_TWO;
      end else if (wake_lt[1]) begin
         found = TASK_FIRST;
      end else begin
         found = TASK_IDLE;
      end
   end

   // next state and result
   always_comb begin
      tick_in     = tick_ff;
      cur_in      = cur_ff;
      slices_in   = slices_ff;
      streak_in   = streak_ff;
      handover_in = handover_ff;
      for (int i = 0; i < TASK_COUNT; i++) begin
         wake_in[i] = wake_ff[i];
      end
      do_switch = 1'b0;
      sw        = 1'b0;
      asleep    = 1'b0;

      case (ev.opcode)
         OP_SLEEP: begin
            wake_in[cur_ff] = tick_ff + {{(TICK_WIDTH-DELAY_WIDTH){1'b0}}, ev.sleep_ticks};
         end
         OP_TICK: begin
            tick_in   = tick_nx;
            do_switch = 1'b1;

            // from idle, take over a worker that is awake
            if (cur_ff == TASK_IDLE) begin
               if (found == TASK_IDLE) begin
                  do_switch = 1'b0;
               end else begin
                  cur_in      = found;
                  handover_in = 1'b1;
               end
            end

            // check the running worker
            if (cur_in != TASK_IDLE) begin
               if (wake_gt[cur_in]) begin
                  asleep    = 1'b1;
                  streak_in = streak_ff + {{(STREAK_WIDTH-1){1'b0}}, 1'b1};
               end else begin
                  streak_in = '0;
                  slices_in = slices_ff - {{(SLICE_WIDTH-1){1'b0}}, 1'b1};
                  if (slices_in != '0) begin
                     do_switch = 1'b0;
                  end
               end
            end

            // switch: idle after too many misses, else rotate unless just taken over
            if (do_switch) begin
               sw = 1'b1;
               if (streak_in == TIMEOUT_MISSES) begin
                  cur_in    = TASK_IDLE;
                  streak_in = '0;
               end else if (!handover_in) begin
                  cur_in = (cur_in == TASK_LAST) ? TASK_FIRST :
                           cur_in + {{(TASK_WIDTH-1){1'b0}}, 1'b1};
               end
               slices_in   = slice_cfg_ff[cur_in];
               handover_in = 1'b0;
            end
         end
         default: ;
      endcase

      res.running_task = cur_in;
      res.switched     = sw;
      res.found_asleep = asleep;
   end

   // state registers, updated once per event
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         cur_ff      <= TASK_LAST;
         slices_ff   <= {{(SLICE_WIDTH-1){1'b0}}, 1'b1};
         streak_ff   <= '0;
         handover_ff <= 1'b0;
         for (int i = 0; i < TASK_COUNT; i++) begin
            wake_ff[i] <= '0;
         end
      end else if (fire) begin
         tick_ff     <= tick_in;
         cur_ff      <= cur_in;
         slices_ff   <= slices_in;
         streak_ff   <= streak_in;
         handover_ff <= handover_in;
         for (int i = 0; i < TASK_COUNT; i++) begin
            wake_ff[i] <= wake_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ----- src/sars_out_reg.sv -----
// result register for response transactions
`timescale 1ns / 1ps
`default_nettype none

module sars_out_reg
   import sars_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire result_type            res,
   output logic                       free,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [TASK_WIDTH-1:0]      rsp_running_task,
   output logic                       rsp_switched,
   output logic                       rsp_found_asleep
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   // free when empty or being taken this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load && free) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_running_task = res_ff.running_task;
   assign rsp_switched     = res_ff.switched;
   assign rsp_found_asleep = res_ff.found_asleep;

endmodule

`default_nettype wire

// ----- src/sleep_aware_round_robin_scheduler.sv -----
// top level of the sleep-aware round-robin task scheduler
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_opcode, req_sleep_ticks
//   rsp_      out        rsp_valid/rsp_ready  rsp_running_task, rsp_switched,
//                                             rsp_found_asleep
//   csr_      in         csr_we               csr_index, csr_wdata
//
// one event per cycle sustained while rsp_ready holds; a taken event passes the
// input register, then decision logic into the result register
// every event gives exactly one result; the state updates as the result is loaded
// synchronous reset sets the state and loads the slice registers' reset values
// a stalled result holds the result register, and the input register takes the
// next event as soon as its held one moves on
`timescale 1ns / 1ps
`default_nettype none

module sleep_aware_round_robin_scheduler
   import sars_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_opcode,
   input  wire logic [DELAY_WIDTH-1:0]   req_sleep_ticks,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [TASK_WIDTH-1:0]         rsp_running_task,
   output logic                          rsp_switched,
   output logic                          rsp_found_asleep,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [SLICE_WIDTH-1:0]   csr_wdata
);

   logic       ev_valid;
   event_type  ev;
   result_type res;
   logic       out_free;
   logic       fire;

   // event moves into the result register when that is free
   assign fire = ev_valid && out_free;

   sars_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_sleep_ticks (req_sleep_ticks),
      .advance         (out_free),
      .ev_valid        (ev_valid),
      .ev              (ev)
   );

   sars_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .ev        (ev),
      .res       (res)
   );

   sars_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (ev_valid),
      .res              (res),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_running_task (rsp_running_task),
      .rsp_switched     (rsp_switched),
      .rsp_found_asleep (rsp_found_asleep)
   );

   // a task found asleep always forces a switch
   a_asleep_switches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_found_asleep || rsp_switched))
      else $error("found_asleep without a switch");

   // a free result register never holds back the input side
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      out_free |-> req_ready)
      else $error("input stalled while result register free");

   // a processed event shows up as a result in the next cycle
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed event gave no result");

endmodule

`default_nettype wire
